[src/adc_pkg.sv]
// Shared codes and widths for the access decision combiner.
package adc_pkg;

  localparam int KIND_W = 2;
  localparam int DEC_W  = 2;
  localparam int ALG_W  = 2;

  // transaction kinds
  localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINALIZE = 2'd2;

  // decision encoding
  localparam logic [DEC_W-1:0] DEC_NA     = 2'd0;
  localparam logic [DEC_W-1:0] DEC_PERMIT = 2'd1;
  localparam logic [DEC_W-1:0] DEC_DENY   = 2'd2;
  localparam logic [DEC_W-1:0] DEC_INDET  = 2'd3;

  // combining algorithms
  localparam logic [ALG_W-1:0] ALG_RULE_DENY     = 2'd0;
  localparam logic [ALG_W-1:0] ALG_POLICY_DENY   = 2'd1;
  localparam logic [ALG_W-1:0] ALG_RULE_PERMIT   = 2'd2;
  localparam logic [ALG_W-1:0] ALG_POLICY_PERMIT = 2'd3;

  // rule effect
  localparam logic EFFECT_PERMIT = 1'b0;
  localparam logic EFFECT_DENY   = 1'b1;

endpackage

[src/adc_in_if.sv]
// Input channel: one decision transaction.
interface adc_in_if;
  logic                       valid;
  logic                       ready;
  logic [adc_pkg::KIND_W-1:0] kind;
  logic [adc_pkg::DEC_W-1:0]  decision;
  logic                       effect;

  modport source (output valid, kind, decision, effect, input ready);
  modport sink   (input valid, kind, decision, effect, output ready);
endinterface

[src/adc_out_if.sv]
// Output channel: combined decision status.
interface adc_out_if;
  logic                      valid;
  logic                      ready;
  logic                      ready_res;
  logic [adc_pkg::DEC_W-1:0] combined;

  modport source (output valid, ready_res, combined, input ready);
  modport sink   (input valid, ready_res, combined, output ready);
endinterface

[src/access_decision_combiner_top.sv]
// Access decision combiner: input register, flag update logic, result register.
// Each transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while the result side accepts; flags update
// as each item leaves the input reg.
// The input register can still accept one transaction while a result waits downstream.
// Synchronous active-high reset clears the algorithm (rule deny-overrides),
// all sticky flags, the settled decision and both valid bits.
module access_decision_combiner_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [adc_pkg::ALG_W-1:0] cfg_data,
  adc_in_if.sink                    item,
  adc_out_if.source                 result
);

  typedef struct packed {
    logic                      rdy;
    logic [adc_pkg::DEC_W-1:0] cur;
    logic                      seen_error;
    logic                      potential_deny;
    logic                      potential_permit;
    logic                      seen_deny;
    logic                      seen_permit;
  } run_state_t;

  localparam run_state_t RUN_CLEAR = '{
    rdy: 1'b0, cur: adc_pkg::DEC_NA, seen_error: 1'b0, potential_deny: 1'b0,
    potential_permit: 1'b0, seen_deny: 1'b0, seen_permit: 1'b0};

  logic [adc_pkg::ALG_W-1:0]  algorithm;
  run_state_t                 st;
  run_state_t                 st_next;

  // input register
  logic                       s1_valid;
  logic [adc_pkg::KIND_W-1:0] s1_kind;
  logic [adc_pkg::DEC_W-1:0]  s1_decision;
  logic                       s1_effect;

  logic                       out_valid;
  logic                       out_ready_res;
  logic [adc_pkg::DEC_W-1:0]  out_combined;

  logic out_free;
  logic proc;
  logic [adc_pkg::DEC_W-1:0] fin_dec;

  assign out_free   = !out_valid || result.ready;
  assign proc       = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;

  assign result.valid     = out_valid;
  assign result.ready_res = out_ready_res;
  assign result.combined  = out_combined;

  // finalize priorities
  always_comb begin
    fin_dec = adc_pkg::DEC_NA;
    case (algorithm)
      adc_pkg::ALG_RULE_DENY: begin
        if (st.potential_deny)   fin_dec = adc_pkg::DEC_INDET;
        else if (st.seen_permit) fin_dec = adc_pkg::DEC_PERMIT;
        else if (st.seen_error)  fin_dec = adc_pkg::DEC_INDET;
      end
      adc_pkg::ALG_RULE_PERMIT: begin
        if (st.potential_permit) fin_dec = adc_pkg::DEC_INDET;
        else if (st.seen_deny)   fin_dec = adc_pkg::DEC_DENY;
        else if (st.seen_error)  fin_dec = adc_pkg::DEC_INDET;
      end
      adc_pkg::ALG_POLICY_DENY: begin
        if (st.seen_permit) fin_dec = adc_pkg::DEC_PERMIT;
      end
      default: begin
        if (st.seen_deny)        fin_dec = adc_pkg::DEC_DENY;
        else if (st.seen_error)  fin_dec = adc_pkg::DEC_INDET;
      end
    endcase
  end

  always_comb begin
    st_next = st;
    case (s1_kind)
      adc_pkg::KIND_START: begin
        st_next = RUN_CLEAR;
      end
      adc_pkg::KIND_ADD: begin
        if (!st.rdy) begin
          case (algorithm)
            adc_pkg::ALG_RULE_DENY: begin
              if (s1_decision == adc_pkg::DEC_DENY) begin
                st_next.rdy = 1'b1;
                st_next.cur = adc_pkg::DEC_DENY;
              end else if (s1_decision == adc_pkg::DEC_INDET) begin
                st_next.seen_error = 1'b1;
                if (s1_effect == adc_pkg::EFFECT_DENY) st_next.potential_deny = 1'b1;
              end else if (s1_decision == adc_pkg::DEC_PERMIT) begin
                st_next.seen_permit = 1'b1;
              end
            end
            adc_pkg::ALG_RULE_PERMIT: begin
              if (s1_decision == adc_pkg::DEC_PERMIT) begin
                st_next.rdy = 1'b1;
                st_next.cur = adc_pkg::DEC_PERMIT;
              end else if (s1_decision == adc_pkg::DEC_INDET) begin
                st_next.seen_error = 1'b1;
                if (s1_effect == adc_pkg::EFFECT_PERMIT) st_next.potential_permit = 1'b1;
              end else if (s1_decision == adc_pkg::DEC_DENY) begin
                st_next.seen_deny = 1'b1;
              end
            end
            adc_pkg::ALG_POLICY_DENY: begin
              // indeterminate counts as deny here
              if (s1_decision inside {adc_pkg::DEC_DENY, adc_pkg::DEC_INDET}) begin
                st_next.rdy = 1'b1;
                st_next.cur = adc_pkg::DEC_DENY;
              end else if (s1_decision == adc_pkg::DEC_PERMIT) begin
                st_next.seen_permit = 1'b1;
              end
            end
            default: begin
              if (s1_decision == adc_pkg::DEC_PERMIT) begin
                st_next.rdy = 1'b1;
                st_next.cur = adc_pkg::DEC_PERMIT;
              end else if (s1_decision == adc_pkg::DEC_DENY) begin
                st_next.seen_deny = 1'b1;
              end else if (s1_decision == adc_pkg::DEC_INDET) begin
                st_next.seen_error = 1'b1;
              end
            end
          endcase
        end
      end
      adc_pkg::KIND_FINALIZE: begin
        if (!st.rdy) begin
          st_next.rdy = 1'b1;
          st_next.cur = fin_dec;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm <= adc_pkg::ALG_RULE_DENY;
      st        <= RUN_CLEAR;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) algorithm <= cfg_data;
      if (item.valid && item.ready) s1_valid <= 1'b1;
      else if (proc)                s1_valid <= 1'b0;
      if (proc) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind     <= item.kind;
      s1_decision <= item.decision;
      s1_effect   <= item.effect;
    end
    if (proc) begin
      out_ready_res <= st_next.rdy;
      out_combined  <= st_next.rdy ? st_next.cur : adc_pkg::DEC_NA;
    end
  end

`ifndef SYNTHESIS
  a_add_keeps_settled: assert property (@(posedge clk) disable iff (rst)
    (proc && s1_kind == adc_pkg::KIND_ADD && st.rdy) |=> (st.rdy && $stable(st.cur)))
    else $error("add changed a settled decision");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && s1_kind == adc_pkg::KIND_START) |=> (st == RUN_CLEAR))
    else $error("start did not clear the run");

  a_finalize_settles: assert property (@(posedge clk) disable iff (rst)
    (proc && s1_kind == adc_pkg::KIND_FINALIZE) |=> (st.rdy && out_ready_res))
    else $error("finalize did not settle the result");

  a_unsettled_is_na: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ready_res || out_combined == adc_pkg::DEC_NA))
    else $error("unsettled result carries a decision");
`endif

endmodule

[dv/tb_access_decision_combiner_top.sv]
// Self-checking testbench for the access decision combiner: directed and random runs.
module tb_access_decision_combiner_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [adc_pkg::KIND_W-1:0] kind_t;
  typedef logic [adc_pkg::DEC_W-1:0]  dec_t;
  typedef logic [adc_pkg::ALG_W-1:0]  alg_t;

  localparam kind_t KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int GAP_PCT      = 12;

  typedef struct packed {
    logic ready_res;
    dec_t combined;
  } status_t;

  logic clk;
  logic rst;
  logic cfg_we;
  alg_t cfg_data;

  adc_in_if  in_ch();
  adc_out_if out_ch();

  access_decision_combiner_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (in_ch),
    .result   (out_ch)
  );

  // mirror of the combiner state
  alg_t m_alg;
  logic m_settled;
  dec_t m_decision;
  logic m_error;
  logic m_pot_deny;
  logic m_pot_permit;
  logic m_deny;
  logic m_permit;

  status_t status_q[$];
  int      mismatches;
  int      cycles;
  bit      steady_flow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= GAP_PCT);
  end

  function automatic void settle(dec_t d);
    m_decision = d;
    m_settled  = 1'b1;
  endfunction

  function automatic status_t combine_step(kind_t k, dec_t d, logic e);
    status_t s;
    dec_t r;
    r = adc_pkg::DEC_NA;
    if (k == adc_pkg::KIND_START) begin
      m_settled    = 1'b0;
      m_decision   = adc_pkg::DEC_NA;
      m_error      = 1'b0;
      m_pot_deny   = 1'b0;
      m_pot_permit = 1'b0;
      m_deny       = 1'b0;
      m_permit     = 1'b0;
    end else if (k == adc_pkg::KIND_ADD && !m_settled) begin
      case (m_alg)
        adc_pkg::ALG_RULE_DENY: begin
          if (d == adc_pkg::DEC_DENY) settle(adc_pkg::DEC_DENY);
          else if (d == adc_pkg::DEC_INDET) begin
            m_error = 1'b1;
            if (e == adc_pkg::EFFECT_DENY) m_pot_deny = 1'b1;
          end else if (d == adc_pkg::DEC_PERMIT) m_permit = 1'b1;
        end
        adc_pkg::ALG_RULE_PERMIT: begin
          if (d == adc_pkg::DEC_PERMIT) settle(adc_pkg::DEC_PERMIT);
          else if (d == adc_pkg::DEC_INDET) begin
            m_error = 1'b1;
            if (e == adc_pkg::EFFECT_PERMIT) m_pot_permit = 1'b1;
          end else if (d == adc_pkg::DEC_DENY) m_deny = 1'b1;
        end
        adc_pkg::ALG_POLICY_DENY: begin
          // indeterminate counts as deny here
          if (d == adc_pkg::DEC_DENY || d == adc_pkg::DEC_INDET) settle(adc_pkg::DEC_DENY);
          else if (d == adc_pkg::DEC_PERMIT) m_permit = 1'b1;
        end
        default: begin
          if (d == adc_pkg::DEC_PERMIT) settle(adc_pkg::DEC_PERMIT);
          else if (d == adc_pkg::DEC_DENY) m_deny = 1'b1;
          else if (d == adc_pkg::DEC_INDET) m_error = 1'b1;
        end
      endcase
    end else if (k == adc_pkg::KIND_FINALIZE && !m_settled) begin
      case (m_alg)
        adc_pkg::ALG_RULE_DENY: begin
          if (m_pot_deny) r = adc_pkg::DEC_INDET;
          else if (m_permit) r = adc_pkg::DEC_PERMIT;
          else if (m_error) r = adc_pkg::DEC_INDET;
        end
        adc_pkg::ALG_RULE_PERMIT: begin
          if (m_pot_permit) r = adc_pkg::DEC_INDET;
          else if (m_deny) r = adc_pkg::DEC_DENY;
          else if (m_error) r = adc_pkg::DEC_INDET;
        end
        adc_pkg::ALG_POLICY_DENY: begin
          if (m_permit) r = adc_pkg::DEC_PERMIT;
        end
        default: begin
          if (m_deny) r = adc_pkg::DEC_DENY;
          else if (m_error) r = adc_pkg::DEC_INDET;
        end
      endcase
      settle(r);
    end
    s.ready_res = m_settled;
    s.combined  = m_settled ? m_decision : adc_pkg::DEC_NA;
    return s;
  endfunction

  always @(posedge clk) begin
    status_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (status_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transaction: ready_res=%0b combined=%0d",
                   out_ch.ready_res, out_ch.combined);
        mismatches++;
      end else begin
        want = status_q.pop_front();
        if (out_ch.ready_res !== want.ready_res || out_ch.combined !== want.combined) begin
          if (mismatches < 10)
            $display("mismatch: expected ready_res=%0b combined=%0d, %s%0b combined=%0d",
                     want.ready_res, want.combined, "got ready_res=",
                     out_ch.ready_res, out_ch.combined);
          mismatches++;
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_item(kind_t k, dec_t d, logic e);
    while (!steady_flow && $urandom_range(99) < GAP_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.decision <= d;
    in_ch.effect   <= e;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    status_q.push_back(combine_step(k, d, e));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_alg(alg_t a);
    in_ch.valid <= 1'b0;
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= a;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_alg = a;
  endtask

  task automatic send_random(kind_t k);
    send_item(k, dec_t'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  task automatic test_unused_kind();
    send_item(KIND_UNUSED, adc_pkg::DEC_INDET, adc_pkg::EFFECT_DENY);
  endtask

  task automatic test_rule_deny();
    write_alg(adc_pkg::ALG_RULE_DENY);
    send_item(adc_pkg::KIND_START, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_NA, adc_pkg::EFFECT_DENY);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_INDET, adc_pkg::EFFECT_DENY);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_PERMIT, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_FINALIZE, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    // settled: adds and a second finalize change nothing
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_DENY, adc_pkg::EFFECT_DENY);
    send_item(adc_pkg::KIND_FINALIZE, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
  endtask

  task automatic test_policy_deny();
    write_alg(adc_pkg::ALG_POLICY_DENY);
    send_item(adc_pkg::KIND_START, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_PERMIT, adc_pkg::EFFECT_DENY);
    send_item(adc_pkg::KIND_FINALIZE, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_START, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_INDET, adc_pkg::EFFECT_PERMIT);
  endtask

  task automatic test_policy_permit();
    write_alg(adc_pkg::ALG_POLICY_PERMIT);
    send_item(adc_pkg::KIND_START, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_FINALIZE, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_START, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_DENY, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_INDET, adc_pkg::EFFECT_DENY);
    send_item(adc_pkg::KIND_FINALIZE, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
  endtask

  // flags gathered under rule permit-overrides, finalized under rule deny-overrides
  task automatic test_switch_midrun();
    write_alg(adc_pkg::ALG_RULE_PERMIT);
    send_item(adc_pkg::KIND_START, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_INDET, adc_pkg::EFFECT_PERMIT);
    send_item(adc_pkg::KIND_ADD, adc_pkg::DEC_DENY, adc_pkg::EFFECT_DENY);
    write_alg(adc_pkg::ALG_RULE_DENY);
    send_item(adc_pkg::KIND_FINALIZE, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT);
  endtask

  task automatic test_random_runs();
    int sent;
    int n_adds;
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) write_alg(adc_pkg::ALG_POLICY_PERMIT);
      else if (ph == 1) write_alg(adc_pkg::ALG_RULE_DENY);
      else write_alg(alg_t'($urandom_range(3)));
      steady_flow = (ph == 6);
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(99) < 85) begin
          send_random(adc_pkg::KIND_START);
          n_adds = int'($urandom_range(6));
          repeat (n_adds) send_random(adc_pkg::KIND_ADD);
          send_random(adc_pkg::KIND_FINALIZE);
          sent += n_adds + 2;
          if ($urandom_range(3) == 0) begin
            send_random(adc_pkg::KIND_ADD);
            send_random(adc_pkg::KIND_FINALIZE);
            sent += 2;
          end
        end else begin
          send_random(kind_t'($urandom_range(3)));
          sent++;
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = adc_pkg::KIND_START;
    in_ch.decision = adc_pkg::DEC_NA;
    in_ch.effect   = adc_pkg::EFFECT_PERMIT;
    out_ch.ready   = 1'b0;
    mismatches     = 0;
    cycles         = 0;
    steady_flow    = 1'b0;
    m_alg          = adc_pkg::ALG_RULE_DENY;
    void'(combine_step(adc_pkg::KIND_START, adc_pkg::DEC_NA, adc_pkg::EFFECT_PERMIT));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_unused_kind();
    test_rule_deny();
    test_policy_deny();
    test_policy_permit();
    test_switch_midrun();
    test_random_runs();

    in_ch.valid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
